>>> design/ptb_pkg.sv
`timescale 1ns / 1ps

package ptb_pkg;

    // Bank geometry
    localparam int CHANNELS = 8;
    localparam int TIME_W   = 64;
    localparam int IVL_W    = 32;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(CHANNELS + 1);
    localparam int BIT_W    = $clog2(TIME_W);

    // Result field widths
    localparam int MASK_W   = 8;
    localparam int STAT_W   = 2;
    localparam int ACNT_W   = 4;

    // Stream widths
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 16;

    // Add request outcome
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } t_add_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DUP,
        S_ADD,
        S_TLOAD,
        S_TDIV,
        S_TUPD,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic dup_step;
        logic add_commit;
        logic div_load;
        logic div_step;
        logic upd;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_add;
        logic idx_last;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> design/ptb_ctrl.sv
`timescale 1ns / 1ps

module ptb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ptb_pkg::t_dp_stat  i_stat,
    output ptb_pkg::t_dp_cmd   o_cmd
);
    import ptb_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_stat.is_add ? S_DUP : S_TLOAD;
            end
            // walk all slots looking for the same interval
            S_DUP: begin
                o_cmd.dup_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add_commit = 1'b1;
                n_state          = S_DONE;
            end
            // per slot: load elapsed time, reduce, update
            S_TLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_TDIV;
            end
            S_TDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_TUPD;
                end
            end
            S_TUPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_stat.idx_last ? S_DONE : S_TLOAD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> design/ptb_dp.sv
`timescale 1ns / 1ps

module ptb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptb_pkg::t_dp_cmd              i_cmd,
    output ptb_pkg::t_dp_stat             o_stat,
    // request fields
    input  logic                          i_command,
    input  logic [ptb_pkg::TIME_W-1:0]    i_time_ms,
    input  logic [ptb_pkg::IVL_W-1:0]     i_interval_ms,
    // result register
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ptb_pkg::MASK_W-1:0]    o_fired_mask,
    output logic [ptb_pkg::STAT_W-1:0]    o_add_status,
    output logic [ptb_pkg::ACNT_W-1:0]    o_active_count
);
    import ptb_pkg::*;

    // Captured request
    logic              r_cmd;
    logic [TIME_W-1:0] r_time;
    logic [IVL_W-1:0]  r_ivl;

    // Bank state
    logic [TIME_W-1:0] r_latest;
    logic              r_valid   [CHANNELS];
    logic [IVL_W-1:0]  r_ivl_mem [CHANNELS];
    logic [TIME_W-1:0] r_last_mem[CHANNELS];
    logic [CNT_W-1:0]  r_count;

    // Walk and remainder unit
    logic [IDX_W-1:0]  r_idx;
    logic              r_dup;
    logic [TIME_W-1:0] r_dividend;
    logic [IVL_W-1:0]  r_rem;
    logic [IVL_W-1:0]  r_per;
    logic [BIT_W-1:0]  r_bitcnt;
    logic              r_fire;
    logic [MASK_W-1:0] r_mask;
    t_add_status       r_status;

    // Result register
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_mask;
    t_add_status       r_out_status;
    logic [CNT_W-1:0]  r_out_count;

    logic [TIME_W-1:0] w_dt;
    logic [IVL_W-1:0]  w_sel_ivl;
    logic [IVL_W:0]    w_rem_sh;
    logic [IVL_W:0]    w_rem_sub;
    logic              w_full;

    assign w_sel_ivl = r_ivl_mem[r_idx];
    assign w_dt      = r_time - r_last_mem[r_idx];
    assign w_rem_sh  = {r_rem, r_dividend[TIME_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_per};
    assign w_full    = (r_count == CNT_W'(CHANNELS));

    assign o_stat.is_add   = r_cmd;
    assign o_stat.idx_last = (r_idx == IDX_W'(CHANNELS - 1));
    assign o_stat.div_done = (r_bitcnt == {BIT_W{1'b1}});
    assign o_stat.out_free = !r_out_valid || i_ready;

    // Request capture and walk control
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_time <= i_time_ms;
            r_ivl  <= i_interval_ms;
        end
        if (i_cmd.start) begin
            r_idx    <= '0;
            r_dup    <= 1'b0;
            r_mask   <= '0;
            r_status <= ST_OK;
        end
        if (i_cmd.dup_step) begin
            if (r_valid[r_idx] && w_sel_ivl == r_ivl) begin
                r_dup <= 1'b1;
            end
            r_idx <= r_idx + 1'b1;
        end
        // add outcome, zero test first, then duplicate, then full
        if (i_cmd.add_commit) begin
            priority if (r_ivl == '0) begin
                r_status <= ST_ZERO;
            end else if (r_dup) begin
                r_status <= ST_DUP;
            end else if (w_full) begin
                r_status <= ST_FULL;
            end else begin
                r_status <= ST_OK;
            end
        end
        // fired slots set their mask bit when they fall in the reported range
        if (i_cmd.upd) begin
            for (int j = 0; j < MASK_W; j++) begin
                if (r_fire && int'(r_idx) == j) begin
                    r_mask[j] <= 1'b1;
                end
            end
            r_idx <= r_idx + 1'b1;
        end
    end

    // Restoring remainder: one dividend bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dividend <= w_dt;
            r_per      <= w_sel_ivl;
            r_rem      <= '0;
            r_bitcnt   <= '0;
            r_fire     <= r_valid[r_idx] && (w_sel_ivl != '0) &&
                          (w_dt >= {{(TIME_W-IVL_W){1'b0}}, w_sel_ivl});
        end
        if (i_cmd.div_step) begin
            r_dividend <= {r_dividend[TIME_W-2:0], 1'b0};
            r_bitcnt   <= r_bitcnt + 1'b1;
            if (!w_rem_sub[IVL_W]) begin
                r_rem <= w_rem_sub[IVL_W-1:0];
            end else begin
                r_rem <= w_rem_sh[IVL_W-1:0];
            end
        end
    end

    // Slot tables; last trigger moves to now minus elapsed mod interval
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_commit && r_ivl != '0 && !r_dup && !w_full) begin
            r_ivl_mem[r_count[IDX_W-1:0]]  <= r_ivl;
            r_last_mem[r_count[IDX_W-1:0]] <= r_latest;
        end
        if (i_cmd.upd && r_fire) begin
            r_last_mem[r_idx] <= r_time - {{(TIME_W-IVL_W){1'b0}}, r_rem};
        end
    end

    // Valid bits, slot count, latest time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latest <= '0;
            r_count  <= '0;
            for (int k = 0; k < CHANNELS; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (i_cmd.start && !r_cmd) begin
                r_latest <= r_time;
            end
            if (i_cmd.add_commit && r_ivl != '0 && !r_dup && !w_full) begin
                r_valid[r_count[IDX_W-1:0]] <= 1'b1;
                r_count                     <= r_count + 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_mask   <= r_mask;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_fired_mask   = r_out_mask;
    assign o_add_status   = r_out_status;
    assign o_active_count = ACNT_W'(r_out_count);

endmodule

>>> design/periodic_timer_bank.sv
`timescale 1ns / 1ps

// Channel   Signals                      Contents (lowest bit first)
// s_axis    tvalid/tready/tdata/tuser    tdata: time_ms[63:0], interval_ms[95:64]
//                                        tuser: command (0 tick, 1 add)
// m_axis    tvalid/tready/tdata          tdata: fired_mask[7:0], add_status[9:8],
//                                        active_count[13:10], zero [15:14]
//
// One request at a time. An add walks all 8 slots for duplicates before it
// commits; a tick runs the 64-step remainder unit once per slot. A new request
// is taken while the previous result waits in the output register; a stalled
// output only holds the next result. Reset is synchronous, active low, and
// clears all slots.

module periodic_timer_bank (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [ptb_pkg::S_DATA_W-1:0]   s_axis_tdata,  // time_ms, interval_ms
    input  logic                           s_axis_tuser,  // command
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ptb_pkg::M_DATA_W-1:0]   m_axis_tdata   // fired_mask, add_status,
                                                          // active_count, pad
);
    import ptb_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_stat          w_stat;
    logic [MASK_W-1:0] w_mask;
    logic [STAT_W-1:0] w_status;
    logic [ACNT_W-1:0] w_count;

    ptb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ptb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_command      (s_axis_tuser),
        .i_time_ms      (s_axis_tdata[TIME_W-1:0]),
        .i_interval_ms  (s_axis_tdata[TIME_W+IVL_W-1:TIME_W]),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_fired_mask   (w_mask),
        .o_add_status   (w_status),
        .o_active_count (w_count)
    );

    assign m_axis_tdata = {{(M_DATA_W-MASK_W-STAT_W-ACNT_W){1'b0}}, w_count, w_status, w_mask};

    // Busy after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready while a request is in progress");

    // A result is only moved into the output register when it is free
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten");

    // Rejected add results carry no fired slots
    a_add_no_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_status != ST_OK) |-> (w_mask == '0))
        else $error("fired mask on a rejected add");

    // Active count never exceeds the bank size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (int'(w_count) <= CHANNELS))
        else $error("active count out of range");

endmodule

>>> tb/sv/periodic_timer_bank_checker.sv
`timescale 1ns / 1ps

// Passive checker for periodic_timer_bank: models the timer table, queues
// the expected result of every accepted request and compares each result.
module periodic_timer_bank_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           i_req_ready,
    input  logic [ptb_pkg::S_DATA_W-1:0]   i_req_data,   // time_ms, interval_ms
    input  logic                           i_req_cmd,    // command (1 = add)
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [ptb_pkg::M_DATA_W-1:0]   i_res_data,   // fired_mask, add_status,
                                                         // active_count, pad
    output int                             o_errors,
    output int                             o_pending
);

    import ptb_pkg::*;

    localparam int PAD_W    = M_DATA_W - MASK_W - STAT_W - ACNT_W;
    localparam int MAX_SHOW = 40;

    // Result layout, highest field first so it lines up with tdata
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [ACNT_W-1:0] count;
        t_add_status       status;
        logic [MASK_W-1:0] fired;
    } t_timer_result;

    // Timer table shadow
    logic [TIME_W-1:0] last_now;
    logic              slot_on   [CHANNELS];
    logic [IVL_W-1:0]  slot_period [CHANNELS];
    logic [TIME_W-1:0] slot_base [CHANNELS];
    int                slot_cnt;

    t_timer_result     expected_q [$];
    int                err_count;
    int                pending_cnt;

    assign o_errors  = err_count;
    assign o_pending = pending_cnt;

    task automatic report_mismatch(input string what);
        if (err_count < MAX_SHOW)
            $display("%0t ns: timer bank mismatch: %s", $time, what);
        err_count++;
    endtask

    // Apply one request to the shadow table and return its result
    function automatic t_timer_result apply_request(input logic is_add,
                                                    input logic [TIME_W-1:0] now_ms,
                                                    input logic [IVL_W-1:0] period);
        t_timer_result     r;
        logic [TIME_W-1:0] dt;
        logic [TIME_W-1:0] per;
        logic              hit;
        r = '0;
        r.status = ST_OK;
        if (is_add) begin
            hit = 1'b0;
            for (int i = 0; i < CHANNELS; i++)
                if (slot_on[i] && slot_period[i] == period)
                    hit = 1'b1;
            // zero beats duplicate beats full
            if (period == '0) begin
                r.status = ST_ZERO;
            end else if (hit) begin
                r.status = ST_DUP;
            end else if (slot_cnt >= CHANNELS) begin
                r.status = ST_FULL;
            end else begin
                slot_on[slot_cnt]     = 1'b1;
                slot_period[slot_cnt] = period;
                slot_base[slot_cnt]   = last_now;
                slot_cnt++;
            end
        end else begin
            last_now = now_ms;
            for (int i = 0; i < CHANNELS; i++) begin
                if (slot_on[i] && slot_period[i] != '0) begin
                    per = {{(TIME_W-IVL_W){1'b0}}, slot_period[i]};
                    dt  = now_ms - slot_base[i];
                    if (dt >= per) begin
                        // advance by whole periods only, no drift
                        slot_base[i] = slot_base[i] + (dt / per) * per;
                        if (i < MASK_W)
                            r.fired[i] = 1'b1;
                    end
                end
            end
        end
        r.count = slot_cnt[ACNT_W-1:0];
        return r;
    endfunction

    // Compare results first, then queue the new request's expectation
    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        if (!i_rst_n) begin
            last_now = '0;
            slot_cnt = 0;
            for (int i = 0; i < CHANNELS; i++) begin
                slot_on[i]     = 1'b0;
                slot_period[i] = '0;
                slot_base[i]   = '0;
            end
            expected_q.delete();
            err_count   = 0;
            pending_cnt = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing pending", i_res_data));
                end else begin
                    want = expected_q.pop_front();
                    if (got.fired !== want.fired)
                        report_mismatch($sformatf("fired_mask %h, want %h",
                                                  got.fired, want.fired));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("add_status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("active_count %0d, want %0d",
                                                  got.count, want.count));
                    if (got.pad !== want.pad)
                        report_mismatch($sformatf("pad bits %b, want zero", got.pad));
                end
            end
            if (i_req_valid && i_req_ready)
                expected_q.push_back(apply_request(i_req_cmd, i_req_data[TIME_W-1:0],
                                                   i_req_data[TIME_W+IVL_W-1:TIME_W]));
            pending_cnt = expected_q.size();
        end
    end

endmodule

>>> tb/sv/periodic_timer_bank_test.sv
`timescale 1ns / 1ps

module periodic_timer_bank_test;

    import ptb_pkg::*;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_ADD    = 1'b1;
    localparam int   RAND_ITEMS = 1000;
    localparam int   MAX_GAP    = 14;
    localparam int   HOLD_AT    = 300;   // result count that starts the long stall
    localparam int   HOLD_LEN   = 4000;
    localparam int   TAIL_WAIT  = 600;   // idle wait after all results are drained

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;   // time_ms[63:0], interval_ms[95:64]
    logic                  s_axis_tuser;   // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;   // fired_mask, add_status, active_count, pad

    int                    errors;
    int                    pending;
    logic                  tx_burst;
    logic                  rx_burst;

    always #6 i_clk = ~i_clk;

    periodic_timer_bank u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    periodic_timer_bank_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_cmd   (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Offer one request after a drawn gap and hold it until taken
    task automatic send_request(input logic cmd, input logic [TIME_W-1:0] now_ms,
                                input logic [IVL_W-1:0] period);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {period, now_ms};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Withdraw the last request, then wait for every result
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // Request side
    initial begin
        logic [TIME_W-1:0] now_ms;
        logic [IVL_W-1:0]  ivl_set [0:7];
        int                pick;
        int                step;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = CMD_TICK;
        s_axis_tdata  = '0;
        i_rst_n       = 1'b0;
        tx_burst      = 1'b0;
        ivl_set[0] = 32'd1;  ivl_set[1] = 32'hFFFF_FFFF; ivl_set[2] = 32'd3;
        ivl_set[3] = 32'd7;  ivl_set[4] = 32'd10;        ivl_set[5] = 32'd100;
        ivl_set[6] = 32'd1000; ivl_set[7] = 32'd2;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, add rejections, extremes, wrap and full table
        send_request(CMD_TICK, '0, '0);
        send_request(CMD_ADD, {TIME_W{1'b1}}, '0);          // zero interval
        send_request(CMD_ADD, '0, ivl_set[0]);
        send_request(CMD_ADD, '0, ivl_set[0]);              // duplicate
        send_request(CMD_ADD, '0, ivl_set[1]);              // widest interval
        send_request(CMD_TICK, 64'd5, {IVL_W{1'b1}});       // interval ignored on tick
        send_request(CMD_TICK, {TIME_W{1'b1}}, '0);         // latest possible time
        send_request(CMD_TICK, 64'd3, '0);                  // time runs backwards
        send_request(CMD_ADD, {TIME_W{1'b1}}, ivl_set[2]);  // add ignores time field
        for (int i = 3; i < 8; i++)
            send_request(CMD_ADD, '0, ivl_set[i]);
        send_request(CMD_ADD, '0, 32'd5);                   // table full
        send_request(CMD_ADD, '0, '0);                      // zero wins over full
        send_request(CMD_ADD, '0, ivl_set[3]);              // duplicate wins over full
        send_request(CMD_TICK, 64'd1003, '0);
        send_request(CMD_TICK, 64'd1003, '0);               // same time again
        send_request(CMD_TICK, {$urandom, $urandom}, {$urandom});
        send_request(CMD_TICK, 64'h8000_0000_0000_0000, '0);
        send_request(CMD_TICK, '0, '0);
        now_ms = '0;

        // Random: mostly advancing ticks, some jumps and backward steps, few adds
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2)
                wait_drained();
            if (n % 50 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_request(CMD_ADD, {$urandom, $urandom}, ivl_set[$urandom_range(0, 7)]);
            end else if (pick < 6) begin
                send_request(CMD_ADD, {$urandom, $urandom}, '0);
            end else if (pick < 10) begin
                send_request(CMD_ADD, {$urandom, $urandom}, $urandom);
            end else begin
                step = $urandom_range(0, 99);
                if (step < 80)
                    now_ms = now_ms + TIME_W'($urandom_range(0, 1500));
                else if (step < 88)
                    now_ms = now_ms - TIME_W'($urandom_range(1, 3000));
                else if (step < 95)
                    now_ms = {$urandom, $urandom};
                else
                    now_ms = now_ms + {24'd0, 8'($urandom_range(0, 255)), $urandom};
                send_request(CMD_TICK, now_ms, $urandom);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        wait_drained();
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("periodic_timer_bank regression: pass");
        else
            $display("periodic_timer_bank regression: fail");
        $finish;
    end

    // Result side: drawn stalls, bursts with none, one long hold-off
    initial begin
        int stall;
        int taken;
        m_axis_tready = 1'b0;
        rx_burst      = 1'b0;
        taken         = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == HOLD_AT)
                stall = HOLD_LEN;
            else
                stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
            if (taken % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    // Run limit
    initial begin
        #40_000_000;
        $display("periodic_timer_bank regression: fail");
        $finish;
    end

endmodule

>>> files.f
design/ptb_pkg.sv
design/ptb_ctrl.sv
design/ptb_dp.sv
design/periodic_timer_bank.sv
tb/sv/periodic_timer_bank_checker.sv
tb/sv/periodic_timer_bank_test.sv
